// File: rtl/core/mciir_pkg.sv
// Package for the multichannel fourth-order IIR unit.
// Field widths, fixed-point constants, history row layout and pipeline tag types.
// No dependencies; used by the channel interfaces and the top level.
package mciir_pkg;

  localparam int unsigned TAPS      = 4;
  localparam int unsigned TAP_W     = $clog2(TAPS);
  localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAPS - 1);

  localparam int unsigned CH_W      = 8;
  localparam int unsigned SMP_W     = 32;
  localparam int unsigned Y_W       = 47;   // signed Q15.32
  localparam int unsigned COEF_W    = 64;   // signed Q4.60
  localparam int unsigned CFG_IDX_W = 4;

  // register map
  localparam logic [CFG_IDX_W-1:0] CFG_FF_BASE = CFG_IDX_W'(TAPS);
  localparam logic [CFG_IDX_W-1:0] CFG_NUM     = CFG_IDX_W'(2 * TAPS);

  // multiplier split: coefficient and output history in 32-bit halves
  localparam int unsigned HALF_W    = 32;
  localparam int unsigned YH_W      = Y_W - HALF_W;
  localparam int unsigned SMP_FRAC  = 32;   // samples enter as Q32.0 integers, aligned to 32 fraction bits

  // products and sum carry 92 fraction bits
  localparam int unsigned FB_W      = COEF_W + Y_W;
  localparam int unsigned FF_W      = COEF_W + SMP_W + 1;
  localparam int unsigned ACC_W     = FF_W + SMP_FRAC + 2;
  localparam int unsigned RND_SHIFT = 60;
  localparam int unsigned RES_W     = ACC_W - RND_SHIFT;
  localparam logic [ACC_W-1:0] RND_BIAS = ACC_W'(1) << (RND_SHIFT - 1);

  // +/-10000.0 in Q15.32
  localparam logic signed [Y_W-1:0] LIMIT_POS = 47'sd42949672960000;
  localparam logic signed [Y_W-1:0] LIMIT_NEG = -LIMIT_POS;

  // one memory row per channel, element 0 is the most recent
  typedef struct packed {
    logic [TAPS-1:0][Y_W-1:0]   y;
    logic [TAPS-1:0][SMP_W-1:0] u;
  } hist_row_t;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [SMP_W-1:0] smp;
    logic             oor;    // channel beyond the configured count
  } item_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } tap_tag_t;

endpackage

// File: rtl/core/mciir_if.sv
// Valid/ready channel interfaces of the multichannel IIR unit:
// sample input, filtered result output and coefficient write port.
// Depends on mciir_pkg.
interface mciir_smp_if;
  import mciir_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CH_W-1:0]         channel;
  logic signed [SMP_W-1:0] sample;
  modport source (output valid, channel, sample, input ready);
  modport sink   (input valid, channel, sample, output ready);
endinterface

interface mciir_res_if;
  import mciir_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CH_W-1:0]       channel_out;
  logic signed [Y_W-1:0] filtered;
  logic                  clipped;
  modport source (output valid, channel_out, filtered, clipped, input ready);
  modport sink   (input valid, channel_out, filtered, clipped, output ready);
endinterface

interface mciir_cfg_if;
  import mciir_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COEF_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/multichannel_iir4_saturating_unit.sv
// Multichannel fourth-order IIR filter with saturating Q15.32 output.
// Depends on mciir_pkg and the interfaces in mciir_if.sv.
//
// Each sample transfer names a channel; the unit returns one result per sample,
// y[n] = sum_k fb_coef_k*y[n-k] + ff_coef_k*u[n-k] (k = 1..4, no feedthrough),
// summed exactly, rounded half up to Q15.32 and clamped to +/-10000 with a clip
// flag. Channel histories live in one CHANNELS-row memory (four outputs and four
// inputs per row) that is read at acceptance and written back after the clamp.
// The four taps share one bank of six 32-bit-class multipliers, one tap per
// cycle while the pipeline does not stall; a new sample is taken only once the
// previous one is at its last tap. A sample for a channel that is still in
// flight is held off until its row is written back. After reset a clearing
// pass zeroes every memory row, during which no samples are taken; coefficient
// writes are always taken and must only happen while the unit is idle.
// Channels at or above CHANNELS return 0 with no clip and leave all history
// untouched.
module multichannel_iir4_saturating_unit #(
  parameter int unsigned CHANNELS = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mciir_cfg_if.sink   cfg_i,
  mciir_smp_if.sink   smp_i,
  mciir_res_if.source res_o
);
  import mciir_pkg::*;

  localparam int unsigned ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CHANNELS - 1);

  // ---------------- coefficients ----------------
  logic [TAPS-1:0][COEF_W-1:0] fb_coef_q, ff_coef_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_coef_q <= '0;
      ff_coef_q <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.index < CFG_FF_BASE) begin
        fb_coef_q[cfg_i.index[TAP_W-1:0]] <= cfg_i.data;
      end else if (cfg_i.index < CFG_NUM) begin
        ff_coef_q[cfg_i.index[TAP_W-1:0]] <= cfg_i.data;
      end
    end
  end

  // ---------------- clearing pass ----------------
  logic              clr_q;
  logic [ADDR_W-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == LAST_ADDR) begin
        clr_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + 1'b1;
    end
  end

  // ---------------- pipeline control ----------------
  logic        adv;        // whole pipeline moves
  logic        mac_vld_q;
  logic [TAP_W-1:0] tap_q;
  item_t       mac_itm_q;
  logic        mac_last;
  tap_tag_t    p_tag_q, q_tag_q;
  logic        sum_vld_q;
  logic        wb_vld_q;
  item_t       wb_itm_q;
  logic        out_vld_q;
  logic        hazard;
  logic        in_xfer;
  logic        in_oor;

  // only stall when a finished sum meets a result that is still waiting
  assign adv      = !(sum_vld_q && out_vld_q && !res_o.ready);
  assign mac_last = mac_vld_q && (tap_q == TAP_LAST);
  assign in_oor   = 32'(smp_i.channel) >= CHANNELS;

  // interlock: row of this channel not yet written back
  assign hazard = (mac_vld_q && (mac_itm_q.ch == smp_i.channel)) ||
                  (wb_vld_q && (wb_itm_q.ch == smp_i.channel));

  assign smp_i.ready = !clr_q && adv && (!mac_vld_q || mac_last) && !hazard;
  assign in_xfer     = smp_i.valid && smp_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_vld_q <= 1'b0;
      tap_q     <= '0;
      p_tag_q   <= '0;
      q_tag_q   <= '0;
      sum_vld_q <= 1'b0;
      wb_vld_q  <= 1'b0;
    end else if (adv) begin
      if (in_xfer) begin
        mac_vld_q <= 1'b1;
        tap_q     <= '0;
      end else if (mac_last) begin
        mac_vld_q <= 1'b0;
      end else if (mac_vld_q) begin
        tap_q <= tap_q + 1'b1;
      end
      p_tag_q   <= '{vld: mac_vld_q, first: (tap_q == '0), last: mac_last};
      q_tag_q   <= p_tag_q;
      sum_vld_q <= q_tag_q.vld && q_tag_q.last;
      if (mac_last) begin
        wb_vld_q <= 1'b1;
      end else if (sum_vld_q) begin
        wb_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      mac_itm_q <= '{ch: smp_i.channel, smp: smp_i.sample, oor: in_oor};
    end
  end

  // ---------------- history memory ----------------
  hist_row_t         hist_mem [CHANNELS];
  hist_row_t         rd_row_q;
  hist_row_t         wb_row;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  hist_row_t         mem_wdata;
  logic [ADDR_W-1:0] rd_addr;

  assign rd_addr = in_oor ? '0 : ADDR_W'(smp_i.channel);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    if (in_xfer) begin
      rd_row_q <= hist_mem[rd_addr];
    end
  end

  // ---------------- tap multipliers (stage P) ----------------
  logic [COEF_W-1:0]        c_fb, c_ff;
  logic [Y_W-1:0]           y_tap;
  logic signed [SMP_W-1:0]  u_tap;
  logic signed [HALF_W-1:0] fb_hi, ff_hi;
  logic signed [HALF_W:0]   fb_lo, ff_lo, y_lo;
  logic signed [YH_W-1:0]   y_hi;

  logic [2*HALF_W-1:0]             fb_ll_d, fb_ll_q;
  logic signed [HALF_W+YH_W:0]     fb_lh_d, fb_lh_q;
  logic signed [2*HALF_W:0]        fb_hl_d, fb_hl_q;
  logic signed [HALF_W+YH_W-1:0]   fb_hh_d, fb_hh_q;
  logic signed [HALF_W+SMP_W-1:0]  ff_h_d, ff_h_q;
  logic signed [HALF_W+SMP_W:0]    ff_l_d, ff_l_q;

  assign c_fb  = fb_coef_q[tap_q];
  assign c_ff  = ff_coef_q[tap_q];
  assign y_tap = rd_row_q.y[tap_q];
  assign u_tap = $signed(rd_row_q.u[tap_q]);

  assign fb_hi = $signed(c_fb[COEF_W-1:HALF_W]);
  assign fb_lo = $signed({1'b0, c_fb[HALF_W-1:0]});
  assign ff_hi = $signed(c_ff[COEF_W-1:HALF_W]);
  assign ff_lo = $signed({1'b0, c_ff[HALF_W-1:0]});
  assign y_hi  = $signed(y_tap[Y_W-1:HALF_W]);
  assign y_lo  = $signed({1'b0, y_tap[HALF_W-1:0]});

  assign fb_ll_d = c_fb[HALF_W-1:0] * y_tap[HALF_W-1:0];
  assign fb_lh_d = fb_lo * y_hi;
  assign fb_hl_d = fb_hi * y_lo;
  assign fb_hh_d = fb_hi * y_hi;
  assign ff_h_d  = ff_hi * u_tap;
  assign ff_l_d  = ff_lo * u_tap;

  // ---------------- product assembly (stage Q) and sum (stage A) ----------------
  logic signed [2*HALF_W+1:0] fb_mid;
  logic signed [FB_W-1:0]     fb_prod_d, fb_prod_q;
  logic signed [FF_W-1:0]     ff_prod_d, ff_prod_q;
  logic signed [ACC_W-1:0]    acc_base, acc_d, acc_q;

  assign fb_mid    = (2*HALF_W+2)'(fb_lh_q) + (2*HALF_W+2)'(fb_hl_q);
  // hh and ll do not overlap, so they concatenate
  assign fb_prod_d = $signed({fb_hh_q, fb_ll_q}) + (FB_W'(fb_mid) <<< HALF_W);
  assign ff_prod_d = (FF_W'(ff_h_q) <<< HALF_W) + FF_W'(ff_l_q);

  assign acc_base = q_tag_q.first ? '0 : acc_q;
  assign acc_d    = acc_base + ACC_W'(fb_prod_q) + (ACC_W'(ff_prod_q) <<< SMP_FRAC);

  always_ff @(posedge clk_i) begin
    if (adv && mac_vld_q) begin
      fb_ll_q <= fb_ll_d;
      fb_lh_q <= fb_lh_d;
      fb_hl_q <= fb_hl_d;
      fb_hh_q <= fb_hh_d;
      ff_h_q  <= ff_h_d;
      ff_l_q  <= ff_l_d;
    end
    if (adv && p_tag_q.vld) begin
      fb_prod_q <= fb_prod_d;
      ff_prod_q <= ff_prod_d;
    end
    if (adv && q_tag_q.vld) begin
      acc_q <= acc_d;
    end
  end

  // rows shifted by one, kept until write-back
  logic [TAPS-2:0][Y_W-1:0]   wb_y_q;
  logic [TAPS-2:0][SMP_W-1:0] wb_u_q;

  always_ff @(posedge clk_i) begin
    if (adv && mac_last) begin
      wb_itm_q <= mac_itm_q;
      wb_y_q   <= rd_row_q.y[TAPS-2:0];
      wb_u_q   <= rd_row_q.u[TAPS-2:0];
    end
  end

  // ---------------- round, clamp, write back (stage S) ----------------
  logic [ACC_W-1:0]        rnd_sum;
  logic signed [RES_W-1:0] res_full;
  logic                    over, under;
  logic signed [Y_W-1:0]   y_new;

  assign rnd_sum  = acc_q + RND_BIAS;
  assign res_full = $signed(rnd_sum[ACC_W-1:RND_SHIFT]);
  assign over     = res_full > RES_W'(LIMIT_POS);
  assign under    = res_full < RES_W'(LIMIT_NEG);

  always_comb begin
    y_new = res_full[Y_W-1:0];
    if (over) begin
      y_new = LIMIT_POS;
    end else if (under) begin
      y_new = LIMIT_NEG;
    end
  end

  assign wb_row.y = {wb_y_q, y_new};
  assign wb_row.u = {wb_u_q, wb_itm_q.smp};

  assign mem_we    = clr_q || (adv && sum_vld_q && !wb_itm_q.oor);
  assign mem_waddr = clr_q ? clr_addr_q : ADDR_W'(wb_itm_q.ch);
  assign mem_wdata = clr_q ? '0 : wb_row;

  // ---------------- result register ----------------
  logic [CH_W-1:0]       out_ch_q;
  logic signed [Y_W-1:0] out_y_q;
  logic                  out_clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && sum_vld_q) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && sum_vld_q) begin
      out_ch_q   <= wb_itm_q.ch;
      out_y_q    <= wb_itm_q.oor ? '0 : y_new;
      out_clip_q <= !wb_itm_q.oor && (over || under);
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.channel_out = out_ch_q;
  assign res_o.filtered    = out_y_q;
  assign res_o.clipped     = out_clip_q;

endmodule

// File: dv/multichannel_iir4_saturating_unit_tb.sv
// Self-checking testbench for the multichannel fourth-order saturating IIR unit.
// Predicts each filtered result from a bit-exact filter model and checks every result transfer.
// Depends on mciir_pkg, the channel interfaces in mciir_if.sv and the unit itself.
module multichannel_iir4_saturating_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mciir_pkg::*;

  localparam int unsigned CHANNELS        = 256;
  localparam int unsigned RUN_LIMIT       = 400_000;
  localparam int unsigned DRAIN_CYCLES    = 50;
  localparam int unsigned ITEMS_PER_PHASE = 400;

  localparam logic signed [COEF_W-1:0] Q_ONE  = 64'sh1000_0000_0000_0000;
  localparam logic signed [COEF_W-1:0] Q_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [COEF_W-1:0] Q_MIN  = 64'sh8000_0000_0000_0000;
  // half of one output lsb for a unit sample
  localparam logic signed [COEF_W-1:0] Q_HALF_LSB = 64'sh0000_0000_0800_0000;
  localparam logic signed [SMP_W-1:0]  S_MAX  = 32'sh7FFF_FFFF;
  localparam logic signed [SMP_W-1:0]  S_MIN  = 32'sh8000_0000;

  typedef struct packed {
    logic [CH_W-1:0]       ch;
    logic signed [Y_W-1:0] y;
    logic                  clip;
  } filt_result_t;

  logic clk = 1'b0;
  logic rst_n;

  mciir_cfg_if cfg_if ();
  mciir_smp_if smp_if ();
  mciir_res_if res_if ();

  multichannel_iir4_saturating_unit #(
    .CHANNELS(CHANNELS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .smp_i (smp_if),
    .res_o (res_if)
  );

  always #1 clk = ~clk;

  // filter model state
  logic signed [COEF_W-1:0] fb_coef_q [TAPS];
  logic signed [COEF_W-1:0] ff_coef_q [TAPS];
  logic signed [Y_W:0]      y_past [CHANNELS][TAPS];
  logic signed [SMP_W-1:0]  u_past [CHANNELS][TAPS];

  filt_result_t pending_results [$];
  int unsigned  mismatches;
  int unsigned  results_seen;
  int unsigned  cycles;
  int unsigned  hold_len;
  int unsigned  hold_reqs;
  bit           tx_idle;
  bit           rx_idle;

  // Exact sum with 92 fraction bits, round half up to Q15.32, clamp, then shift
  // the channel's histories. Every 8-bit channel is below CHANNELS.
  function automatic filt_result_t iir_predict(input logic [CH_W-1:0] ch,
                                               input logic signed [SMP_W-1:0] smp);
    logic signed [191:0] acc;
    logic signed [191:0] coef;
    logic signed [191:0] hist;
    logic signed [191:0] rounded;
    logic signed [Y_W:0] y_new;
    filt_result_t        r;
    acc = '0;
    r.ch = ch;
    r.clip = 1'b0;
    for (int k = 0; k < TAPS; k++) begin
      coef = fb_coef_q[k];
      hist = y_past[ch][k];
      acc += coef * hist;
      coef = ff_coef_q[k];
      hist = u_past[ch][k];
      acc += coef * (hist <<< SMP_FRAC);
    end
    rounded = (acc + (192'sd1 <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
    if (rounded > LIMIT_POS) begin
      y_new = LIMIT_POS;
      r.clip = 1'b1;
    end else if (rounded < LIMIT_NEG) begin
      y_new = LIMIT_NEG;
      r.clip = 1'b1;
    end else begin
      y_new = rounded[Y_W:0];
    end
    for (int k = TAPS - 1; k > 0; k--) begin
      y_past[ch][k] = y_past[ch][k-1];
      u_past[ch][k] = u_past[ch][k-1];
    end
    y_past[ch][0] = y_new;
    u_past[ch][0] = smp;
    r.y = y_new[Y_W-1:0];
    return r;
  endfunction

  function automatic logic [COEF_W-1:0] to_q360(input real v);
    return longint'(v * 2.0**60);
  endfunction

  function automatic logic signed [COEF_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string field, input longint want, input longint got);
    mismatches++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  task automatic send_sample(input logic [CH_W-1:0] ch, input logic signed [SMP_W-1:0] smp);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      smp_if.valid <= 1'b0;
    end
    @(negedge clk);
    smp_if.valid   <= 1'b1;
    smp_if.channel <= ch;
    smp_if.sample  <= smp;
    do @(posedge clk); while (smp_if.ready !== 1'b1);
    pending_results.push_back(iir_predict(ch, smp));
  endtask

  // sender stops and waits for every outstanding result
  task automatic wait_idle();
    @(negedge clk);
    smp_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    if (idx < CFG_FF_BASE)
      fb_coef_q[idx[TAP_W-1:0]] = val;
    else if (idx < CFG_NUM)
      ff_coef_q[idx[TAP_W-1:0]] = val;
  endtask

  // only called with nothing in flight
  task automatic program_coefs(input logic [COEF_W-1:0] fb1, fb2, fb3, fb4,
                               input logic [COEF_W-1:0] ff1, ff2, ff3, ff4);
    logic [COEF_W-1:0] regs [2*TAPS];
    regs = '{fb1, fb2, fb3, fb4, ff1, ff2, ff3, ff4};
    for (int i = 0; i < 2 * TAPS; i++)
      cfg_write(CFG_IDX_W'(i), regs[i]);
    // index past the map, must leave the coefficients alone
    cfg_write(CFG_IDX_W'($urandom_range(CFG_NUM, (1 << CFG_IDX_W) - 1)), rand64());
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_file_coefs();
    program_coefs(to_q360(3.9943512468013100), to_q360(-5.9830635921697510),
                  to_q360(3.9830734372540126), to_q360(-0.9943610918871258),
                  to_q360(0.0000000022018152), to_q360(-0.0000000020966603),
                  to_q360(-0.0000000022470842), to_q360(0.0000000021434835));
  endtask

  // coefficients still zero, histories cleared
  task automatic test_cleared_state();
    send_sample(8'd0, S_MAX);
    send_sample(8'd255, S_MIN);
    send_sample(8'd0, -32'sd1);
    send_sample(8'd255, 32'sd0);
    send_sample(8'd128, 32'sd1);
    wait_idle();
  endtask

  task automatic test_tap_weights();
    program_coefs(Q_ONE / 2, -(Q_ONE / 4), Q_MAX, Q_MIN, Q_ONE, -Q_ONE, 64'sd1, -64'sd1);
    send_sample(8'd7, 32'sd100);
    send_sample(8'd7, -32'sd3);
    send_sample(8'd7, 32'sd7);
    send_sample(8'd7, 32'sd0);
    send_sample(8'd7, 32'sd0);
    send_sample(8'd7, 32'sd0);
    wait_idle();
  endtask

  // exact halves round toward plus infinity
  task automatic test_rounding();
    program_coefs(64'd0, 64'd0, 64'd0, 64'd0, Q_HALF_LSB, 64'd0, 64'd0, 64'd0);
    send_sample(8'd3, 32'sd1);
    send_sample(8'd3, -32'sd1);
    send_sample(8'd3, 32'sd3);
    send_sample(8'd3, -32'sd3);
    send_sample(8'd3, 32'sd0);
    wait_idle();
  endtask

  // exactly at the limit passes, one whole unit beyond clips, both signs
  task automatic test_saturation();
    program_coefs(64'd0, 64'd0, 64'd0, 64'd0, Q_ONE, 64'd0, 64'd0, 64'd0);
    send_sample(8'd255, 32'sd10000);
    send_sample(8'd255, 32'sd10001);
    send_sample(8'd255, -32'sd10000);
    send_sample(8'd255, -32'sd10001);
    send_sample(8'd255, 32'sd0);
    wait_idle();
    program_coefs(Q_MAX, Q_MIN, 64'd0, 64'd0, Q_MAX, Q_MIN, 64'd0, 64'd0);
    send_sample(8'd254, S_MAX);
    send_sample(8'd254, S_MIN);
    send_sample(8'd254, 32'sd0);
    wait_idle();
  endtask

  // receiver holds off while samples keep coming, so the input stalls
  task automatic test_backpressure();
    load_file_coefs();
    tx_idle = 1'b0;
    hold_len = 300;
    hold_reqs++;
    for (int i = 0; i < 48; i++)
      send_sample(CH_W'(i % 6), $urandom);
    wait_idle();
    tx_idle = 1'b1;
  endtask

  task automatic test_random_filter();
    int unsigned             r;
    logic [CH_W-1:0]         pool [4];
    logic [CH_W-1:0]         ch;
    logic signed [SMP_W-1:0] smp;
    logic [COEF_W-1:0]       extremes [5];
    extremes = '{Q_MAX, Q_MIN, 64'd0, Q_ONE, -Q_ONE};
    ch = '0;
    smp = '0;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          load_file_coefs();
          tx_idle = 1'b1;
          rx_idle = 1'b1;
        end
        1: begin
          program_coefs(rand64() >>> 4, rand64() >>> 4, rand64() >>> 4, rand64() >>> 4,
                        rand64() >>> 4, rand64() >>> 4, rand64() >>> 4, rand64() >>> 4);
          tx_idle = 1'b0;
          rx_idle = 1'b1;
        end
        2: begin
          program_coefs(rand64(), rand64(), rand64(), rand64(),
                        rand64(), rand64(), rand64(), rand64());
          tx_idle = 1'b1;
          rx_idle = 1'b0;
        end
        default: begin
          program_coefs(extremes[$urandom_range(0, 4)], extremes[$urandom_range(0, 4)],
                        extremes[$urandom_range(0, 4)], extremes[$urandom_range(0, 4)],
                        extremes[$urandom_range(0, 4)], extremes[$urandom_range(0, 4)],
                        extremes[$urandom_range(0, 4)], extremes[$urandom_range(0, 4)]);
          tx_idle = 1'b0;
          rx_idle = 1'b0;
        end
      endcase
      foreach (pool[i]) pool[i] = CH_W'($urandom_range(0, CHANNELS - 1));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 49) == 0)
          wait_idle();
        // mostly a few channels so histories build up; repeats hit the in-flight hold
        r = $urandom_range(0, 9);
        if (r < 7)
          ch = pool[$urandom_range(0, 3)];
        else if (r < 9)
          ch = CH_W'($urandom_range(0, CHANNELS - 1));
        r = $urandom_range(0, 19);
        if (r < 10)
          smp = $signed($urandom_range(0, 2000)) - 1000;
        else if (r < 15)
          smp = $urandom;
        else if (r < 17) begin
          case ($urandom_range(0, 3))
            0:       smp = S_MAX;
            1:       smp = S_MIN;
            2:       smp = '0;
            default: smp = -32'sd1;
          endcase
        end
        send_sample(ch, smp);
      end
      wait_idle();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // result receiver: random stall after each transfer while rx_idle is set, long hold on request
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    int unsigned served;
    stall = 0;
    taken = 0;
    served = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != served) begin
        served = hold_reqs;
        taken = results_seen;
        stall = hold_len;
      end else if (results_seen != taken) begin
        taken = results_seen;
        stall = rx_idle ? $urandom_range(0, 5) : 0;
      end
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    filt_result_t want;
    if (rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, channel_out", -1, res_if.channel_out);
      end else begin
        want = pending_results.pop_front();
        if (res_if.channel_out !== want.ch)
          report_mismatch("channel_out", want.ch, res_if.channel_out);
        if (res_if.filtered !== want.y)
          report_mismatch("filtered", $signed(want.y), $signed(res_if.filtered));
        if (res_if.clipped !== want.clip)
          report_mismatch("clipped", want.clip, res_if.clipped);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    smp_if.valid   = 1'b0;
    smp_if.channel = '0;
    smp_if.sample  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    tx_idle        = 1'b1;
    rx_idle        = 1'b1;
    hold_len       = 0;
    hold_reqs      = 0;
    foreach (fb_coef_q[k]) begin
      fb_coef_q[k] = '0;
      ff_coef_q[k] = '0;
    end
    foreach (y_past[c, k]) begin
      y_past[c][k] = '0;
      u_past[c][k] = '0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_cleared_state();
    test_tap_weights();
    test_rounding();
    test_saturation();
    test_backpressure();
    test_random_filter();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
